@@ rtl/core/blp_pkg.sv @@
// Shared types, constants and functions of the byte-level pre-tokeniser.
package blp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [8:0] CP_LOW_BASE = 9'h100;
    localparam logic [8:0] CP_MID_OFFSET = 9'd162;
    localparam logic [8:0] CP_SOFT_HYPHEN = 9'd323;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_SPACE,
        CLS_WS,
        CLS_ALPHA,
        CLS_DIGIT,
        CLS_OTHER
    } blp_cls_t;

    typedef struct packed {
        logic [7:0] byte_val;
        blp_cls_t   cls;
        logic [8:0] cp;
        logic       last;
    } blp_rec_t;

    function automatic blp_cls_t byte_class(input logic [7:0] b);
        blp_cls_t c;
        if (b == 8'd32)
            c = CLS_SPACE;
        else if (b == 8'd9 || b == 8'd10 || b == 8'd13)
            c = CLS_WS;
        else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122))
            c = CLS_ALPHA;
        else if (b >= 8'd48 && b <= 8'd57)
            c = CLS_DIGIT;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    function automatic logic [8:0] byte_codepoint(input logic [7:0] b);
        logic       printable;
        logic [8:0] cp;
        printable = (b >= 8'd33 && b <= 8'd126) || (b >= 8'd161 && b <= 8'd172)
                 || (b >= 8'd174);
        if (printable)
            cp = {1'b0, b};
        else if (b <= 8'd32)
            cp = CP_LOW_BASE + {1'b0, b};
        else if (b <= 8'd160)
            cp = {1'b0, b} + CP_MID_OFFSET;
        else
            cp = CP_SOFT_HYPHEN;
        return cp;
    endfunction

    function automatic logic is_white(input blp_cls_t c);
        return (c == CLS_SPACE) || (c == CLS_WS);
    endfunction

    function automatic logic starts_chunk(input blp_cls_t prev, input blp_cls_t cur,
                                          input blp_cls_t nxt);
        logic s;
        if (prev == CLS_NONE)
            s = 1'b1;
        else if (is_white(cur))
        begin
            if (!is_white(prev))
                s = 1'b1;
            else
                s = (cur == CLS_SPACE) && (nxt != CLS_NONE) && !is_white(nxt);
        end
        else if (prev == cur || prev == CLS_SPACE)
            s = 1'b0;
        else
            s = 1'b1;
        return s;
    endfunction

endpackage

@@ rtl/core/blp_front.sv @@
// Front part: accepts text bytes, classifies them and passes records to the queue.
module blp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              q_push,
    output blp_pkg::blp_rec_t q_rec
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    blp_pkg::blp_rec_t stage_rec_reg;
    logic              accept;

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_rec  = stage_rec_reg;

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (q_push)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_rec_reg.byte_val <= text_byte;
            stage_rec_reg.cls      <= blp_pkg::byte_class(text_byte);
            stage_rec_reg.cp       <= blp_pkg::byte_codepoint(text_byte);
            stage_rec_reg.last     <= end_of_text;
        end
    end

endmodule

@@ rtl/core/blp_queue.sv @@
// Short queue of classified records between the front and back parts.
module blp_queue
#(
    parameter int DEPTH = blp_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  blp_pkg::blp_rec_t wr_rec,
    output logic              q_full,
    input  logic              rd_en,
    output blp_pkg::blp_rec_t rd_rec,
    output logic              q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blp_pkg::blp_rec_t  store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_rec  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

@@ rtl/core/blp_back.sv @@
// Back part: holds one byte, decides chunk starts and drives the result register.
module blp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  blp_pkg::blp_rec_t q_rec,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic [8:0]        codepoint,
    output logic              chunk_start,
    output logic              final_result
);

    logic              held_valid_reg;
    logic              held_valid_next;
    blp_pkg::blp_rec_t held_reg;
    blp_pkg::blp_rec_t held_next;
    blp_pkg::blp_cls_t before_reg;
    blp_pkg::blp_cls_t before_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic [8:0]        codepoint_reg;
    logic [8:0]        codepoint_next;
    logic              chunk_start_reg;
    logic              chunk_start_next;
    logic              final_reg;
    logic              final_next;
    logic              slot_free;
    logic              emit;
    logic              take;

    assign empty        = !out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign codepoint    = codepoint_reg;
    assign chunk_start  = chunk_start_reg;
    assign final_result = final_reg;
    assign slot_free    = !out_valid_reg || pop;
    assign q_pop        = take;

    // A final byte that meets a held byte is worked in two steps: the held byte
    // leaves first, its class becomes the predecessor, and the record stays at the head.
    always_comb
    begin
        emit             = 1'b0;
        take             = 1'b0;
        held_valid_next  = held_valid_reg;
        held_next        = held_reg;
        before_next      = before_reg;
        out_byte_next    = out_byte_reg;
        codepoint_next   = codepoint_reg;
        chunk_start_next = chunk_start_reg;
        final_next       = final_reg;
        if (!q_empty)
        begin
            if (held_valid_reg)
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    out_byte_next    = held_reg.byte_val;
                    codepoint_next   = held_reg.cp;
                    chunk_start_next = blp_pkg::starts_chunk(before_reg, held_reg.cls,
                                                             q_rec.cls);
                    final_next       = 1'b0;
                    held_valid_next  = 1'b0;
                    before_next      = held_reg.cls;
                    if (!q_rec.last)
                    begin
                        take            = 1'b1;
                        held_next       = q_rec;
                        held_valid_next = 1'b1;
                    end
                end
            end
            else if (q_rec.last)
            begin
                if (slot_free)
                begin
                    emit             = 1'b1;
                    take             = 1'b1;
                    out_byte_next    = q_rec.byte_val;
                    codepoint_next   = q_rec.cp;
                    chunk_start_next = blp_pkg::starts_chunk(before_reg, q_rec.cls,
                                                             blp_pkg::CLS_NONE);
                    final_next       = 1'b1;
                    before_next      = blp_pkg::CLS_NONE;
                end
            end
            else
            begin
                take            = 1'b1;
                held_next       = q_rec;
                held_valid_next = 1'b1;
            end
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            before_reg     <= blp_pkg::CLS_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            before_reg     <= before_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg        <= held_next;
        out_byte_reg    <= out_byte_next;
        codepoint_reg   <= codepoint_next;
        chunk_start_reg <= chunk_start_next;
        final_reg       <= final_next;
    end

endmodule

@@ rtl/core/byte_level_pretokenizer_unit.sv @@
// Top level of the byte-level pre-tokeniser.
// Accepts one text byte per clock cycle while full is low and gives at most one
// result item per cycle. Each byte leaves as a result once its successor is known:
// the successor passes the input stage register and the queue, and the result for
// the byte is then written to the result register. A final byte with nothing held
// is offered once it has passed the input stage register, the queue and the result
// register. A final byte that meets a held byte makes two results: the back part
// emits the held byte first and the final byte after it; QUEUE_DEPTH records between
// the front and back parts absorb such pauses and stalls on the result side.
module byte_level_pretokenizer_unit
#(
    parameter int QUEUE_DEPTH = blp_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [8:0] codepoint,
    output logic       chunk_start,
    output logic       final_result
);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    blp_pkg::blp_rec_t wr_rec;
    blp_pkg::blp_rec_t rd_rec;

    blp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (wr_rec)
    );

    blp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_rec  (wr_rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_rec  (rd_rec),
        .q_empty (q_empty)
    );

    blp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rec        (rd_rec),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .codepoint    (codepoint),
        .chunk_start  (chunk_start),
        .final_result (final_result)
    );

endmodule
